// File: rtl/bounded_deque_with_match_count_unit_defines.svh
// Assertion macros used by the top-level RTL file of the deque unit.
// BDQ_ASSERT is disabled while reset is high; BDQ_ASSERT_RST also checks
// during reset and is meant for properties about the reset itself.
// Both expect signals named clock and reset in the scope of use.
`ifndef BOUNDED_DEQUE_WITH_MATCH_COUNT_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_MATCH_COUNT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define BDQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define BDQ_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define BDQ_ASSERT(name, prop, msg)

`define BDQ_ASSERT_RST(name, prop, msg)

`endif

`endif

// File: rtl/bdq_pkg.sv
package bdq_pkg;

   // Fixed field widths of the request and response beats.
   localparam int IN_WORD_W  = 32;
   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int OUT_COUNT_W = 7;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_COUNT      = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

// File: rtl/bdq_ram.sv
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bounded_deque_with_match_count_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_opcode, req_push_value, req_match_key
// rsp_      out        rsp_valid / rsp_stall  rsp_status, rsp_match_count, rsp_occupancy
//
// A push, pop or unused opcode has its response registered at the edge that
// accepts the request.
// A count issues one RAM read per stored entry through a single comparator,
// then compares the last registered read data, and then loads the response
// register.
// Reset (synchronous, active high) empties the deque; the entry RAM is not cleared.
// The request side stalls while a count is scanning and while an unread
// response is held back by rsp_stall.
`include "bounded_deque_with_match_count_unit_defines.svh"

module bounded_deque_with_match_count_unit
   import bdq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic signed [IN_WORD_W-1:0] req_push_value,
   input  logic signed [IN_WORD_W-1:0] req_match_key,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [OUT_COUNT_W-1:0]      rsp_match_count,
   output logic [OUT_COUNT_W-1:0]      rsp_occupancy
);

   // Address width of the circular store, and a count width that can hold DEPTH.
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // Scan sequencer: read pointer, entries still to read, and a flag telling
   // that the RAM output holds an entry to compare this cycle.
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   logic                  pend_ff, pend_in;
   logic [CNT_W-1:0]      match_ff, match_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_match_ff, rsp_match_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  req_accept;
   logic                  rsp_take;
   logic                  is_full;
   logic                  is_empty;
   logic [AW-1:0]         head_prev;
   logic [AW-1:0]         head_next;
   logic [AW-1:0]         ptr_next;
   logic [SUM_W-1:0]      back_sum;
   logic [AW-1:0]         back_slot;
   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] key_word;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The block keeps the low DATA_WIDTH bits of the 32-bit words; wider
   // configurations see the words zero-extended.
   assign push_word = DATA_WIDTH'($unsigned(req_push_value));
   assign key_word  = DATA_WIDTH'($unsigned(req_match_key));

   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Circular index arithmetic; DEPTH need not be a power of two.
   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign ptr_next  = (ptr_ff == AW'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign back_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? AW'(back_sum - SUM_W'(DEPTH))
                                                  : AW'(back_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      match_ff      <= match_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      remain_in     = remain_ff;
      pend_in       = pend_ff;
      match_in      = match_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      rsp_status_in = rsp_status_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_match_in  = '0;
               rsp_occ_in    = count_ff;
               unique case (opcode_type'(req_opcode))
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        head_in    = head_prev;
                        wr_en      = 1'b1;
                        wr_addr    = head_prev;
                        count_in   = count_ff + 1'b1;
                        rsp_occ_in = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                        count_in   = count_ff + 1'b1;
                        rsp_occ_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        head_in    = head_next;
                        count_in   = count_ff - 1'b1;
                        rsp_occ_in = count_ff - 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        count_in   = count_ff - 1'b1;
                        rsp_occ_in = count_ff - 1'b1;
                     end
                  end
                  OP_COUNT: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // The response waits until the scan is finished.
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        ptr_in       = head_ff;
                        remain_in    = count_ff;
                        pend_in      = 1'b0;
                        match_in     = '0;
                        key_in       = key_word;
                     end
                  end
                  default: begin
                     // Unused opcodes leave the deque as it is.
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one read per entry from front to back; the comparison of
            // an entry happens the cycle after its read.
            pend_in = (remain_ff != '0);
            if (remain_ff != '0) begin
               rd_en     = 1'b1;
               rd_addr   = ptr_ff;
               ptr_in    = ptr_next;
               remain_in = remain_ff - 1'b1;
            end
            if (pend_ff && (rd_data == key_ff)) begin
               match_in = match_ff + 1'b1;
            end
            if ((remain_ff == '0) && !pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_match_in  = match_ff;
               rsp_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_count = OUT_COUNT_W'(rsp_match_ff);
   assign rsp_occupancy   = OUT_COUNT_W'(rsp_occ_ff);

   // The occupancy never exceeds the store size.
   `BDQ_ASSERT(a_count_bounded, count_ff <= CNT_W'(DEPTH), "occupancy exceeds depth")

   // No request is taken while a count is scanning.
   `BDQ_ASSERT(a_stall_in_scan, (state_ff == ST_SCAN) |-> req_stall, "request taken during scan")

   // A scan can never find more matches than entries held.
   `BDQ_ASSERT(a_match_bounded, (state_ff == ST_SCAN) |-> (match_ff <= count_ff),
               "match count exceeds occupancy")

   // An accepted push into a deque with room grows it by exactly one entry.
   `BDQ_ASSERT(a_push_grows,
               (req_accept && !is_full && ((req_opcode == OP_PUSH_FRONT) ||
                (req_opcode == OP_PUSH_BACK))) |=>
               (count_ff == CNT_W'($past(count_ff) + 1'b1)),
               "push did not add one entry")

   // Reset leaves the deque empty and the sequencer idle.
   `BDQ_ASSERT_RST(a_reset_clears, reset |=> ((count_ff == '0) && (state_ff == ST_IDLE) &&
                   !rsp_valid_ff), "reset did not clear the deque")

endmodule
